FILE: hw/rtl/sitrd_pkg.sv
// Shared constants and widths for the signed integer to radix digits block.
package sitrd_pkg;

  localparam int MAX_SYMBOLS = 16;
  localparam int MAX_DIGITS  = 32;

  localparam int VALUE_W   = 32;
  localparam int SYM_W     = 8;
  localparam int SYMWORD_W = 64;
  localparam int BASE_W    = 5;
  localparam int DIGIT_W   = $clog2(MAX_SYMBOLS);
  localparam int IDX_W     = $clog2(MAX_DIGITS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int DIVCNT_W  = $clog2(VALUE_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE    = 2'd2;

  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;

endpackage

FILE: hw/rtl/signed_int_to_radix_digits.sv
// Top level: signed 32-bit value to text in a configured radix, one byte per item.
//
// Each accepted value is converted to text in the radix set by base_size, using the
// alphabet in symbols_low/symbols_high. The digits come from a shared one-bit-per-cycle
// restoring divider, one division per digit; a base-2 value has up to 32 digits.
// Each output character is then read from the digit store and loaded into the output
// register, waiting while the receiver stalls; a negative value gets '-' first and
// zero gives a single '0'. The input is stalled for the whole conversion and opens
// again once the last character sits in the output register. With an invalid
// alphabet the value is taken and dropped with no output. The user must write
// configuration only while the block is idle; the block itself does not enforce it.
module signed_int_to_radix_digits
  import sitrd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SYMWORD_W-1:0] cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [VALUE_W-1:0] value,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SYM_W-1:0]     character,
  output logic                 last
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_SIGN = 6'b000100,
    ST_READ = 6'b001000,
    ST_EMIT = 6'b010000,
    ST_ZERO = 6'b100000
  } state_t;

  // configuration registers
  logic [SYMWORD_W-1:0] symbols_low;
  logic [SYMWORD_W-1:0] symbols_high;
  logic [BASE_W-1:0]    base_size;

  // sequencer state
  state_t             state, state_next;
  logic               negative_flag, negative_flag_next;
  logic [CNT_W-1:0]   digit_count, digit_count_next;
  logic [IDX_W-1:0]   rd_ptr, rd_ptr_next;

  // datapath
  logic               alpha_ok;
  logic               accept;
  logic [VALUE_W-1:0] mag_in;
  logic               div_start;
  logic [VALUE_W-1:0] div_dividend;
  logic               div_done;
  logic [VALUE_W-1:0] div_quot;
  logic [DIGIT_W-1:0] div_rem;
  logic               mem_we;
  logic               mem_re;
  logic [DIGIT_W-1:0] mem_rdata;
  logic [2*SYMWORD_W-1:0] sym_table;

  // output register control
  logic               out_free;
  logic               push;
  logic [SYM_W-1:0]   push_char;
  logic               push_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_low  <= '0;
      symbols_high <= '0;
      base_size    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        REG_BASE_SIZE:    base_size    <= cfg_data[BASE_W-1:0];
        default:          ;
      endcase
    end
  end

  sitrd_alpha_check u_alpha (
    .symbols_low  (symbols_low),
    .symbols_high (symbols_high),
    .base_size    (base_size),
    .ok           (alpha_ok)
  );

  sitrd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (base_size),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // digits land least significant first at digit_count, read back from the top
  sitrd_digit_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (digit_count[IDX_W-1:0]),
    .wdata (div_rem),
    .re    (mem_re),
    .raddr (rd_ptr),
    .rdata (mem_rdata)
  );

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  // most negative value wraps to 2^31, which is exact as unsigned
  assign mag_in    = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
  assign sym_table = {symbols_high, symbols_low};
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    state_next         = state;
    negative_flag_next = negative_flag;
    digit_count_next   = digit_count;
    rd_ptr_next        = rd_ptr;
    div_start          = 1'b0;
    div_dividend       = div_quot;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    push               = 1'b0;
    push_char          = CHAR_ZERO;
    push_last          = 1'b0;
    case (state)
      ST_IDLE: begin
        // bad alphabet: item dropped, state untouched
        if (accept && alpha_ok) begin
          negative_flag_next = value[VALUE_W-1];
          digit_count_next   = '0;
          if (mag_in == '0) begin
            state_next = ST_ZERO;
          end else begin
            div_start    = 1'b1;
            div_dividend = mag_in;
            state_next   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mem_we           = 1'b1;
          digit_count_next = digit_count + CNT_W'(1);
          if (div_quot != '0) begin
            div_start = 1'b1;
          end else begin
            // top digit sits at the index just written
            rd_ptr_next = digit_count[IDX_W-1:0];
            state_next  = negative_flag ? ST_SIGN : ST_READ;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          push       = 1'b1;
          push_char  = CHAR_MINUS;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        mem_re     = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          push      = 1'b1;
          push_char = sym_table[{mem_rdata, 3'b000} +: SYM_W];
          push_last = (rd_ptr == '0);
          if (rd_ptr == '0) begin
            state_next = ST_IDLE;
          end else begin
            rd_ptr_next = rd_ptr - IDX_W'(1);
            state_next  = ST_READ;
          end
        end
      end
      ST_ZERO: begin
        if (out_free) begin
          push       = 1'b1;
          push_char  = CHAR_ZERO;
          push_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      negative_flag <= 1'b0;
      digit_count   <= '0;
      rd_ptr        <= '0;
    end else begin
      state         <= state_next;
      negative_flag <= negative_flag_next;
      digit_count   <= digit_count_next;
      rd_ptr        <= rd_ptr_next;
    end
  end

  // output register: holds a character until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      character <= push_char;
      last      <= push_last;
    end
  end

  // digit count never runs past the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  // divider finishes only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider done outside divide state");

  // loading the final character returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (push && push_last) |=> (state == ST_IDLE))
    else $error("last character without return to idle");

  // a push never overwrites a character still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("output register overwritten");

endmodule

FILE: hw/rtl/sitrd_alpha_check.sv
// Alphabet validity check over the configured symbol registers.
module sitrd_alpha_check
  import sitrd_pkg::*;
(
  input  logic [SYMWORD_W-1:0] symbols_low,
  input  logic [SYMWORD_W-1:0] symbols_high,
  input  logic [BASE_W-1:0]    base_size,
  output logic                 ok
);

  logic [SYM_W-1:0] sym [MAX_SYMBOLS];

  always_comb begin
    for (int k = 0; k < MAX_SYMBOLS; k++) begin
      if (k < 8) begin
        sym[k] = symbols_low[k*SYM_W +: SYM_W];
      end else begin
        sym[k] = symbols_high[(k-8)*SYM_W +: SYM_W];
      end
    end
  end

  always_comb begin
    ok = (base_size >= BASE_W'(2)) && (base_size <= BASE_W'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (BASE_W'(i) < base_size) begin
        if (sym[i] == CHAR_NUL || sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if (BASE_W'(j) < base_size && sym[j] == sym[i]) begin
            ok = 1'b0;
          end
        end
      end
    end
  end

endmodule

FILE: hw/rtl/sitrd_divider.sv
// Restoring divider: 32-bit dividend by the radix, one quotient bit per cycle.
module sitrd_divider
  import sitrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  input  logic [BASE_W-1:0]  divisor,
  output logic               done,
  output logic [VALUE_W-1:0] quot,
  output logic [DIGIT_W-1:0] rem
);

  logic                busy;
  logic [DIVCNT_W-1:0] cnt;
  logic [DIGIT_W:0]    trial;
  logic                qbit;

  // divisor <= 16 keeps the partial remainder within DIGIT_W bits
  assign trial = {rem, quot[VALUE_W-1]};
  assign qbit  = (trial >= divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIVCNT_W'(1);
        if (cnt == DIVCNT_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[VALUE_W-2:0], qbit};
      rem  <= qbit ? DIGIT_W'(trial - divisor) : trial[DIGIT_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/sitrd_digit_store.sv
// Digit store: one write port, one registered read port.
module sitrd_digit_store
  import sitrd_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [IDX_W-1:0]   waddr,
  input  logic [DIGIT_W-1:0] wdata,
  input  logic               re,
  input  logic [IDX_W-1:0]   raddr,
  output logic [DIGIT_W-1:0] rdata
);

  logic [DIGIT_W-1:0] mem [MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
